// ===== sv/fdr_pkg.sv =====
package fdr_pkg;

   // Default number of bytes the frame store holds, including the '@'.
   localparam int STORE_DEPTH_DEF = 10;

   // Smallest fill count at which a line feed closes a frame.
   localparam int MIN_FRAME_LEN = 4;

   // Character codes.
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SKIP,
      ST_DIGITS,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic start;
      logic pos_inc;
      logic set_neg;
      logic acc_step;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_end;
      logic pos_at_end;
      logic cur_space;
      logic cur_sign;
      logic cur_digit;
   } status_type;

endpackage

// ===== sv/fdr_datapath.sv =====
module fdr_datapath #(
   parameter int STORE_DEPTH = fdr_pkg::STORE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  fdr_pkg::cmd_type    cmd,
   output fdr_pkg::status_type status,
   input  logic [7:0]          req_rx_byte,
   output logic signed [15:0]  rsp_decoded_value
);

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
   localparam logic [CNT_W-1:0] MIN_C   = CNT_W'(fdr_pkg::MIN_FRAME_LEN);

   logic [7:0]       store_ff [STORE_DEPTH];
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] end_ff, end_in;
   logic             neg_ff, neg_in;
   logic [15:0]      acc_ff, acc_in;
   logic [15:0]      out_ff, out_in;

   logic             is_at;
   logic             can_store;
   logic [CNT_W-1:0] fill_inc;
   logic [7:0]       cur_byte;
   logic [3:0]       digit;

   assign is_at     = (req_rx_byte == fdr_pkg::CHAR_AT);
   assign can_store = !is_at && (fill_ff != '0) && (fill_ff < DEPTH_C);
   assign fill_inc  = fill_ff + CNT_W'(1);
   assign cur_byte  = store_ff[pos_ff[IDX_W-1:0]];
   assign digit     = cur_byte[3:0] - fdr_pkg::CHAR_ZERO[3:0];

   always_comb begin
      status.frame_end  = can_store && (req_rx_byte == fdr_pkg::CHAR_LF) &&
                          (fill_inc >= MIN_C);
      status.pos_at_end = (pos_ff == end_ff);
      status.cur_space  = (cur_byte == fdr_pkg::CHAR_SPACE) ||
                          ((cur_byte >= fdr_pkg::CHAR_TAB) &&
                           (cur_byte <= fdr_pkg::CHAR_CR));
      status.cur_sign   = (cur_byte == fdr_pkg::CHAR_PLUS) ||
                          (cur_byte == fdr_pkg::CHAR_MINUS);
      status.cur_digit  = (cur_byte >= fdr_pkg::CHAR_ZERO) &&
                          (cur_byte <= fdr_pkg::CHAR_NINE);
   end

   always_comb begin
      fill_in = fill_ff;
      pos_in  = pos_ff;
      end_in  = end_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      out_in  = out_ff;
      if (cmd.accept) begin
         if (is_at) begin
            fill_in = CNT_W'(1);
         end else if (can_store) begin
            fill_in = status.frame_end ? '0 : fill_inc;
         end
      end
      if (cmd.start) begin
         // Payload runs from entry 1 up to the entry before the last two.
         pos_in = CNT_W'(1);
         end_in = fill_ff - CNT_W'(1);
         neg_in = 1'b0;
         acc_in = '0;
      end
      if (cmd.pos_inc) begin
         pos_in = pos_ff + CNT_W'(1);
      end
      if (cmd.set_neg) begin
         neg_in = (cur_byte == fdr_pkg::CHAR_MINUS);
      end
      if (cmd.acc_step) begin
         acc_in = (acc_ff << 3) + (acc_ff << 1) + {12'd0, digit};
      end
      if (cmd.load_out) begin
         out_in = neg_ff ? (16'd0 - acc_ff) : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      end_ff <= end_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (cmd.accept && ((is_at && i == 0) ||
             (can_store && fill_ff[IDX_W-1:0] == IDX_W'(i)))) begin
            store_ff[i] <= req_rx_byte;
         end
      end
   end

   assign rsp_decoded_value = out_ff;

endmodule

// ===== sv/fdr_controller.sv =====
module fdr_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  fdr_pkg::status_type status,
   output fdr_pkg::cmd_type    cmd
);

   fdr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         fdr_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && status.frame_end) begin
               cmd.start = 1'b1;
               state_in  = fdr_pkg::ST_SKIP;
            end
         end
         fdr_pkg::ST_SKIP: begin
            priority if (status.pos_at_end) begin
               state_in = fdr_pkg::ST_DONE;
            end else if (status.cur_space) begin
               cmd.pos_inc = 1'b1;
            end else if (status.cur_sign) begin
               cmd.set_neg = 1'b1;
               cmd.pos_inc = 1'b1;
               state_in    = fdr_pkg::ST_DIGITS;
            end else begin
               state_in = fdr_pkg::ST_DIGITS;
            end
         end
         fdr_pkg::ST_DIGITS: begin
            if (!status.pos_at_end && status.cur_digit) begin
               cmd.acc_step = 1'b1;
               cmd.pos_inc  = 1'b1;
            end else begin
               state_in = fdr_pkg::ST_DONE;
            end
         end
         fdr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = fdr_pkg::ST_IDLE;
            end
         end
         default: state_in = fdr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/framed_ascii_decimal_receiver.sv =====
// Framed ASCII decimal receiver.
//
// The request channel carries one received character per transaction on
// req_rx_byte. Frames have the form '@', payload, two trailing bytes (CR LF);
// a line feed that brings the stored count to four or more closes the frame.
// The payload is then read like C atoi: leading whitespace, an optional sign,
// and decimal digits up to the first non-digit, wrapped to 16 bits.
// The response channel carries one transaction per closed frame with the
// signed value on rsp_decoded_value; other bytes produce no response.
//
// Ordinary bytes are taken one per cycle while no conversion runs, so they
// may arrive back to back. The closing line feed starts the conversion,
// which walks the stored payload one character per cycle; the response
// follows once the payload is walked (at most seven characters with the
// default store depth). req_stall is high while the conversion runs.
// The result sits in an output register, so new bytes are taken while it
// waits; if rsp_stall holds it while a second conversion finishes, that
// conversion waits in its final step and req_stall stays high until the
// first result is taken. Reset clears the frame and any pending result.
module framed_ascii_decimal_receiver #(
   parameter int STORE_DEPTH = fdr_pkg::STORE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_decoded_value
);

   // Commands and status between the sequencer and the datapath.
   fdr_pkg::cmd_type    cmd;
   fdr_pkg::status_type status;

   fdr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the frame store, fill count, the conversion pointer
   // and accumulator, and the output register.
   fdr_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_rx_byte       (req_rx_byte),
      .rsp_decoded_value (rsp_decoded_value)
   );

endmodule

// ===== sv/fdr_checker.sv =====
module fdr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_rx_byte,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_decoded_value
);

   // After reset the block is ready and has no pending result.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!req_stall && !rsp_valid))
      else $error("block not idle after reset");

   // Only a line feed can start a conversion.
   a_non_lf_no_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_rx_byte != fdr_pkg::CHAR_LF) |=> !req_stall)
      else $error("input stalled after a byte that cannot close a frame");

   // A new result is only loaded at the end of a conversion.
   a_result_after_conv: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a conversion");

   // A held result stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_decoded_value)))
      else $error("stalled result changed");

endmodule

bind framed_ascii_decimal_receiver fdr_checker u_fdr_checker (.*);

// ===== tb/frame_value_checker.sv =====
`timescale 1ns / 100ps

module frame_value_checker #(
   parameter int STORE_DEPTH = fdr_pkg::STORE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_decoded_value,
   output int                 error_count,
   output int                 pending_results
);

   logic [7:0]         frame_bytes [STORE_DEPTH];
   int unsigned        byte_count;
   logic signed [15:0] last_decoded;
   logic signed [15:0] decoded_queue [$];

   // Reads payload entries 1 .. payload_len the way atoi does and keeps
   // the low 16 bits of the 32-bit result.
   function automatic logic [15:0] atoi_low16(input int unsigned payload_len);
      int unsigned pos;
      int unsigned stop;
      logic [31:0] acc;
      logic        negative;
      pos = 1;
      stop = 1 + payload_len;
      if (stop > STORE_DEPTH) stop = STORE_DEPTH;
      acc = '0;
      negative = 1'b0;
      while (pos < stop && (frame_bytes[pos] == fdr_pkg::CHAR_SPACE ||
             (frame_bytes[pos] >= fdr_pkg::CHAR_TAB &&
              frame_bytes[pos] <= fdr_pkg::CHAR_CR)))
         pos++;
      if (pos < stop && (frame_bytes[pos] == fdr_pkg::CHAR_PLUS ||
                         frame_bytes[pos] == fdr_pkg::CHAR_MINUS)) begin
         negative = (frame_bytes[pos] == fdr_pkg::CHAR_MINUS);
         pos++;
      end
      while (pos < stop && frame_bytes[pos] >= fdr_pkg::CHAR_ZERO &&
             frame_bytes[pos] <= fdr_pkg::CHAR_NINE) begin
         acc = acc * 32'd10 + 32'(frame_bytes[pos] - fdr_pkg::CHAR_ZERO);
         pos++;
      end
      if (negative) acc = -acc;
      return acc[15:0];
   endfunction

   initial begin
      error_count = 0;
      pending_results = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         byte_count = 0;
         last_decoded = 16'sd6;
         decoded_queue.delete();
      end else begin
         // Inputs are taken first, so an expectation is in place before its result.
         if (req_valid && !req_stall) begin
            if (req_rx_byte == fdr_pkg::CHAR_AT) begin
               frame_bytes[0] = req_rx_byte;
               byte_count = 1;
            end else if (byte_count != 0 && byte_count < STORE_DEPTH) begin
               frame_bytes[byte_count] = req_rx_byte;
               byte_count++;
               if (req_rx_byte == fdr_pkg::CHAR_LF &&
                   byte_count >= fdr_pkg::MIN_FRAME_LEN) begin
                  last_decoded = atoi_low16(byte_count - 3);
                  byte_count = 0;
                  decoded_queue.push_back(last_decoded);
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_queue.size() == 0) begin
               $error("decoded_value: expected none, actual %0d", rsp_decoded_value);
               error_count++;
            end else if (rsp_decoded_value !== decoded_queue[0]) begin
               $error("decoded_value: expected %0d, actual %0d",
                      decoded_queue[0], rsp_decoded_value);
               error_count++;
               void'(decoded_queue.pop_front());
            end else begin
               void'(decoded_queue.pop_front());
            end
         end
      end
      pending_results = decoded_queue.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // Total number of received bytes driven, directed part included.
   localparam int TOTAL_BYTES = 1800;
   // The final stretch of the run goes without any idling on either side.
   localparam int QUIET_TAIL = 250;
   // Idling is switched on or off for stretches of this many bytes.
   localparam int PHASE_BYTES = 200;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_decoded_value;

   int mismatch_count;
   int pending_results;
   int bytes_sent;
   bit idling_on;

   always #5ns clock = ~clock;

   framed_ascii_decimal_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_value (rsp_decoded_value)
   );

   // The checker watches both channels, keeps its own copy of the frame
   // store, and compares each decoded value with the oldest expectation.
   frame_value_checker value_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_value (rsp_decoded_value),
      .error_count       (mismatch_count),
      .pending_results   (pending_results)
   );

   // Drives one byte transaction. It is entered at a falling edge and returns
   // at the falling edge after the byte was taken. When a gap is inserted,
   // valid drops at this edge and rises at a later one, so the two never
   // share a time step; back-to-back bytes keep valid high throughout.
   task automatic send_byte(input logic [7:0] value);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      // The stall seen right after the edge is the value from before it.
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
   endtask

   // Holds the sender off until every decoded value owed so far has arrived.
   task automatic drain_results();
      req_valid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clock);
   endtask

   // One frame that mostly follows the expected layout: '@', optional
   // whitespace, optional sign, digits, sometimes a stray byte, then a
   // trailer byte (usually a carriage return) and a line feed. Now and then
   // the payload is long enough to fill the store, which leaves the frame
   // open, and a random trailer may itself restart or close the frame early.
   task automatic send_frame();
      logic [7:0]  body [$];
      int unsigned ws_pick;
      int unsigned sign_pick;
      int unsigned max_len;
      body = {};
      max_len = ($urandom_range(0, 11) == 0) ? 12 : 7;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            ws_pick = $urandom_range(8, 13);
            body.push_back((ws_pick == 8) ? fdr_pkg::CHAR_SPACE : 8'(ws_pick));
         end
      end
      sign_pick = $urandom_range(0, 3);
      if (sign_pick == 0) body.push_back(fdr_pkg::CHAR_PLUS);
      else if (sign_pick == 1) body.push_back(fdr_pkg::CHAR_MINUS);
      repeat ($urandom_range(0, 9))
         body.push_back(fdr_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 5) == 0) body.push_back(8'($urandom_range(0, 255)));
      while (body.size() > max_len) void'(body.pop_back());
      send_byte(fdr_pkg::CHAR_AT);
      foreach (body[i]) send_byte(body[i]);
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                fdr_pkg::CHAR_CR);
      send_byte(fdr_pkg::CHAR_LF);
   endtask

   // The result side stalls in bursts while idling is on.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      bit pressure_done;
      int next_phase;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      idling_on   = 1'b1;
      bytes_sent  = 0;
      pressure_done = 1'b0;
      next_phase  = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. A byte with no frame open is ignored.
      send_byte(8'h00);
      // A line feed at a count below four stays in the payload; the third
      // one closes the frame and the payload is a lone line feed, read as 0.
      send_byte(fdr_pkg::CHAR_AT);
      repeat (3) send_byte(fdr_pkg::CHAR_LF);
      // Tab is skipped, the sign is taken, NUL stops the digits, and the
      // all-ones byte before the line feed is dropped without a check.
      send_byte(fdr_pkg::CHAR_AT);
      send_byte(fdr_pkg::CHAR_TAB);
      send_text("-9");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(fdr_pkg::CHAR_LF);
      // Longest payload the store allows; the value wraps to 16 bits.
      send_text("@9999999");
      send_byte(fdr_pkg::CHAR_CR);
      send_byte(fdr_pkg::CHAR_LF);
      // The carriage return fills the store, so the line feed and the
      // digit after it are ignored and the frame stays open.
      send_text("@+1234567");
      send_byte(fdr_pkg::CHAR_CR);
      send_byte(fdr_pkg::CHAR_LF);
      send_text("7");
      // Let the block go completely quiet once before the random part.
      drain_results();

      // Random part: mostly frames with random content, the rest noise.
      // The next '@' also restarts any frame the directed part left open.
      while (bytes_sent < TOTAL_BYTES) begin
         if (bytes_sent >= TOTAL_BYTES - QUIET_TAIL) begin
            idling_on = 1'b0;
         end else if (bytes_sent >= next_phase) begin
            idling_on = ($urandom_range(0, 3) != 0);
            next_phase = bytes_sent + PHASE_BYTES;
         end
         if ($urandom_range(0, 4) != 0) begin
            send_frame();
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
         if (!pressure_done && bytes_sent >= TOTAL_BYTES / 2) begin
            drain_results();
            pressure_done = 1'b1;
         end
      end

      // Wait for the last decoded value, then give the block time to settle
      // so a stray extra result would still be caught.
      req_valid <= 1'b0;
      wait (pending_results == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
